// File: src/aaba_pkg.sv
// ============================================================================
// aaba_pkg
// Shared types and constants for the aligned arena bump allocator.
// ============================================================================
`default_nettype none

package aaba_pkg;

  // Number of arena slots held in the table.
  localparam int ARENA_SLOTS = 4;
  // Width of a slot index into the table.
  localparam int SLOT_W = (ARENA_SLOTS > 1) ? $clog2(ARENA_SLOTS) : 1;
  // Width of the arena_id and granted_id fields.
  localparam int ID_W = 2;
  // Only slots whose index fits in granted_id can be claimed by create.
  localparam int CREATE_LIMIT = (ARENA_SLOTS < (1 << ID_W)) ? ARENA_SLOTS : (1 << ID_W);
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RESET   = 2'd2,
    OP_DESTROY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BAD    = 2'd1,
    ST_ROOM   = 2'd2,
    ST_NOSLOT = 2'd3
  } status_t;

  typedef struct packed {
    logic              live;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] used;
  } slot_t;

  // One write into the slot table.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    slot_t             data;
  } slot_upd_t;

  // One result item.
  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   granted;
    logic [DATA_W-1:0] address;
    logic [DATA_W-1:0] remaining;
  } result_t;

endpackage

`default_nettype wire

// File: src/aaba_slot_table.sv
// ============================================================================
// aaba_slot_table
// Register-held arena table with one write port and all slots visible.
// ============================================================================
`default_nettype none

module aaba_slot_table (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire aaba_pkg::slot_upd_t upd,
  output aaba_pkg::slot_t          slots [aaba_pkg::ARENA_SLOTS]
);

  aaba_pkg::slot_t table_q [aaba_pkg::ARENA_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < aaba_pkg::ARENA_SLOTS; i++) begin
        table_q[i] <= '0;
      end
    end else if (upd.en) begin
      table_q[upd.idx] <= upd.data;
    end
  end

  assign slots = table_q;

endmodule

`default_nettype wire

// File: src/aaba_exec.sv
// ============================================================================
// aaba_exec
// Combinational command logic: slot search, align-up, fit check, result.
// ============================================================================
`default_nettype none

module aaba_exec (
  input  wire aaba_pkg::op_t              op,
  input  wire logic [aaba_pkg::ID_W-1:0]   arena_id,
  input  wire logic [aaba_pkg::DATA_W-1:0] byte_count,
  input  wire logic [aaba_pkg::DATA_W-1:0] alignment,
  input  wire logic [aaba_pkg::DATA_W-1:0] region_base,
  input  wire aaba_pkg::slot_t             slots [aaba_pkg::ARENA_SLOTS],
  output aaba_pkg::result_t                res,
  output aaba_pkg::slot_upd_t              upd
);

  logic                              free_found;
  logic [aaba_pkg::SLOT_W-1:0]       free_idx;
  logic                              id_in_range;
  logic [aaba_pkg::SLOT_W-1:0]       sel;
  aaba_pkg::slot_t                   cur;
  logic [aaba_pkg::DATA_W-1:0]       mask;
  logic                              pow2;
  logic [aaba_pkg::DATA_W:0]         start;
  logic [aaba_pkg::DATA_W-1:0]       room;
  logic                              nofit;
  logic [aaba_pkg::DATA_W-1:0]       left_now;

  // Lowest free slot among those that create may claim.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = aaba_pkg::CREATE_LIMIT - 1; i >= 0; i--) begin
      if (!slots[i].live) begin
        free_found = 1'b1;
        free_idx   = aaba_pkg::SLOT_W'(i);
      end
    end
  end

  assign id_in_range = (32'(arena_id) < aaba_pkg::ARENA_SLOTS);
  assign sel         = id_in_range ? aaba_pkg::SLOT_W'(arena_id) : '0;
  assign cur         = slots[sel];
  assign left_now    = cur.size - cur.used;

  // Align-up carried in one extra bit so that it never wraps.
  assign mask  = alignment - aaba_pkg::DATA_W'(1);
  assign pow2  = (alignment != '0) && ((alignment & mask) == '0);
  assign start = ({1'b0, cur.used} + {1'b0, mask}) & ~{1'b0, mask};
  assign room  = cur.size - start[aaba_pkg::DATA_W-1:0];
  assign nofit = (start > {1'b0, cur.size}) || (byte_count > room);

  always_comb begin
    res         = '0;
    res.status  = aaba_pkg::ST_OK;
    upd         = '0;
    upd.idx     = sel;
    upd.data    = cur;
    case (op)
      aaba_pkg::OP_CREATE: begin
        if ((byte_count != '0) && free_found) begin
          upd.en        = 1'b1;
          upd.idx       = free_idx;
          upd.data.live = 1'b1;
          upd.data.base = region_base;
          upd.data.size = byte_count;
          upd.data.used = '0;
          res.granted   = aaba_pkg::ID_W'(free_idx);
          res.remaining = byte_count;
        end else begin
          res.status = aaba_pkg::ST_NOSLOT;
        end
      end
      default: begin
        if (!(id_in_range && cur.live)) begin
          res.status = aaba_pkg::ST_BAD;
        end else begin
          case (op)
            aaba_pkg::OP_ALLOC: begin
              if (!pow2) begin
                res.status    = aaba_pkg::ST_BAD;
                res.remaining = left_now;
              end else if (nofit) begin
                res.status    = aaba_pkg::ST_ROOM;
                res.remaining = left_now;
              end else begin
                upd.en        = 1'b1;
                upd.data.used = start[aaba_pkg::DATA_W-1:0] + byte_count;
                res.address   = cur.base + start[aaba_pkg::DATA_W-1:0];
                res.remaining = room - byte_count;
              end
            end
            aaba_pkg::OP_RESET: begin
              upd.en        = 1'b1;
              upd.data.used = '0;
              res.remaining = cur.size;
            end
            default: begin
              upd.en   = 1'b1;
              upd.data = '0;
            end
          endcase
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/aligned_arena_bump_allocator.sv
// ============================================================================
// aligned_arena_bump_allocator
// Bump-pointer allocator over a small table of arenas, one request per cycle unless the result side stalls.
// ============================================================================
// The block takes one request per clock cycle unless the result channel
// stalls, and answers each with exactly one result: a request is captured
// in an input register, decoded against the arena table, and its result
// lands in the result register at the same edge that the table is updated,
// so back-to-back requests always see the effect of the one before.
// Create claims the lowest free slot for a nonzero size; allocate rounds
// the used count up to a power-of-two alignment without wraparound and
// hands out base plus the aligned offset; reset empties an arena and
// destroy frees its slot. Every result carries the remaining bytes of the
// arena it addressed.
`default_nettype none

module aligned_arena_bump_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [1:0]  arena_id,
  input  wire logic [31:0] byte_count,
  input  wire logic [31:0] alignment,
  input  wire logic [31:0] region_base,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [1:0]       granted_id,
  output logic [31:0]      address,
  output logic [31:0]      remaining
);

  // Input register.
  logic                              req_valid;
  aaba_pkg::op_t                     req_op;
  logic [aaba_pkg::ID_W-1:0]         req_id;
  logic [aaba_pkg::DATA_W-1:0]       req_count;
  logic [aaba_pkg::DATA_W-1:0]       req_align;
  logic [aaba_pkg::DATA_W-1:0]       req_base;

  // Result register.
  logic                              res_valid;
  aaba_pkg::result_t                 res_q;

  aaba_pkg::slot_t                   slots [aaba_pkg::ARENA_SLOTS];
  aaba_pkg::result_t                 res_next;
  aaba_pkg::slot_upd_t               upd_raw;
  aaba_pkg::slot_upd_t               upd;
  logic                              advance;

  // The decoded request moves on whenever the result register is free or
  // being emptied in this cycle.
  assign advance  = !res_valid || out_ready;
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op    <= aaba_pkg::op_t'(op);
      req_id    <= arena_id;
      req_count <= byte_count;
      req_align <= alignment;
      req_base  <= region_base;
    end
  end

  aaba_exec u_exec (
    .op          (req_op),
    .arena_id    (req_id),
    .byte_count  (req_count),
    .alignment   (req_align),
    .region_base (req_base),
    .slots       (slots),
    .res         (res_next),
    .upd         (upd_raw)
  );

  // The table is only written when the request actually leaves the input
  // register, so a stalled request never updates an arena twice.
  always_comb begin
    upd    = upd_raw;
    upd.en = upd_raw.en && req_valid && advance;
  end

  aaba_slot_table u_table (
    .clk   (clk),
    .rst   (rst),
    .upd   (upd),
    .slots (slots)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      res_q <= res_next;
    end
  end

  assign out_valid  = res_valid;
  assign status     = res_q.status;
  assign granted_id = res_q.granted;
  assign address    = res_q.address;
  assign remaining  = res_q.remaining;

  // Table consistency: a live arena never has more used than its size, and
  // a free slot is fully cleared.
  logic table_bad;

  always_comb begin
    table_bad = 1'b0;
    for (int i = 0; i < aaba_pkg::ARENA_SLOTS; i++) begin
      if (slots[i].live && (slots[i].used > slots[i].size)) begin
        table_bad = 1'b1;
      end
      if (!slots[i].live && ((slots[i].size != '0) || (slots[i].used != '0))) begin
        table_bad = 1'b1;
      end
    end
  end

  a_table_consistent : assert property (@(posedge clk) disable iff (rst)
    !table_bad)
    else $error("arena table holds an inconsistent slot");

  a_fail_has_no_grant : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != aaba_pkg::ST_OK) |-> (address == '0) && (granted_id == '0))
    else $error("failed request reports an address or a granted slot");

  a_stall_holds_request : assert property (@(posedge clk) disable iff (rst)
    req_valid && !advance |=> req_valid && $stable(req_op) && $stable(req_id))
    else $error("stalled request was lost or changed");

endmodule

`default_nettype wire

// File: dv/tb_aligned_arena_bump_allocator.sv
// ============================================================================
// tb_aligned_arena_bump_allocator
// Self-checking testbench for the aligned arena bump allocator.
// ============================================================================
// A set of directed test tasks covers the corners of each command. A random
// mix of mostly well-formed arena traffic follows under several idle and
// stall patterns, and one long hold-off on the result side backs the block
// up. Every accepted request is run through a local model of the arena table.
// Each result that leaves the block is compared field by field against the
// oldest outstanding prediction.
// ============================================================================

module tb_aligned_arena_bump_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  // Hard ceiling on run length, far above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  // One request as the testbench builds it before driving the ports.
  typedef struct packed {
    aaba_pkg::op_t op;
    logic [1:0]    id;
    logic [31:0]   count;
    logic [31:0]   align;
    logic [31:0]   base;
  } arena_request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = '0;
  logic [1:0]  arena_id = '0;
  logic [31:0] byte_count = '0;
  logic [31:0] alignment = '0;
  logic [31:0] region_base = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [1:0]  granted_id;
  logic [31:0] address;
  logic [31:0] remaining;

  // The testbench copy of the arena table, updated as requests are accepted.
  logic        slot_live [aaba_pkg::ARENA_SLOTS];
  logic [31:0] slot_base [aaba_pkg::ARENA_SLOTS];
  logic [31:0] slot_size [aaba_pkg::ARENA_SLOTS];
  logic [31:0] slot_used [aaba_pkg::ARENA_SLOTS];

  // Results predicted for accepted requests, oldest first.
  aaba_pkg::result_t owed_results[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  // Percent chance of an idle cycle before each request, and of the receiver
  // dropping out_ready on a given cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // While nonzero, the receiver keeps out_ready low and counts this down.
  int unsigned hold_left = 0;

  aligned_arena_bump_allocator dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .arena_id    (arena_id),
    .byte_count  (byte_count),
    .alignment   (alignment),
    .region_base (region_base),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .granted_id  (granted_id),
    .address     (address),
    .remaining   (remaining)
  );

  always #2 clk = ~clk;

  // The run is cut off here if the block stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Arena table model
  // --------------------------------------------------------------------------

  // Bytes still free in a slot, or zero if the slot is not live.
  function automatic logic [31:0] bytes_left(int unsigned idx);
    if (idx >= aaba_pkg::ARENA_SLOTS || !slot_live[idx]) return '0;
    return slot_size[idx] - slot_used[idx];
  endfunction

  // Applies one request to the table copy and returns the result it earns.
  function automatic aaba_pkg::result_t arena_table_apply(arena_request_t req);
    aaba_pkg::result_t res;
    logic [63:0]       align64;
    logic [63:0]       size64;
    logic [63:0]       start;
    bit                found;
    res = '0;
    res.status = aaba_pkg::ST_OK;
    found = 1'b0;
    if (req.op == aaba_pkg::OP_CREATE) begin
      // Lowest free slot wins, and only for a nonzero size.
      if (req.count != '0) begin
        for (int i = 0; i < aaba_pkg::CREATE_LIMIT; i++) begin
          if (!found && !slot_live[i]) begin
            slot_live[i] = 1'b1;
            slot_base[i] = req.base;
            slot_size[i] = req.count;
            slot_used[i] = '0;
            res.granted = i[aaba_pkg::ID_W-1:0];
            found = 1'b1;
          end
        end
      end
      if (found) res.remaining = bytes_left(res.granted);
      else res.status = aaba_pkg::ST_NOSLOT;
    end else begin
      if (req.id >= aaba_pkg::ARENA_SLOTS || !slot_live[req.id]) begin
        res.status = aaba_pkg::ST_BAD;
      end else if (req.op == aaba_pkg::OP_ALLOC) begin
        align64 = {32'd0, req.align};
        if (align64 == '0 || (align64 & (align64 - 64'd1)) != '0) begin
          res.status = aaba_pkg::ST_BAD;
        end else begin
          // The align-up is done in 64 bits so that it never wraps.
          size64 = {32'd0, slot_size[req.id]};
          start = ({32'd0, slot_used[req.id]} + align64 - 64'd1) & ~(align64 - 64'd1);
          if (start > size64 || {32'd0, req.count} > size64 - start) begin
            res.status = aaba_pkg::ST_ROOM;
          end else begin
            slot_used[req.id] = start[31:0] + req.count;
            res.address = slot_base[req.id] + start[31:0];
          end
        end
      end else if (req.op == aaba_pkg::OP_RESET) begin
        slot_used[req.id] = '0;
      end else begin
        slot_live[req.id] = 1'b0;
        slot_base[req.id] = '0;
        slot_size[req.id] = '0;
        slot_used[req.id] = '0;
      end
      res.remaining = bytes_left(req.id);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  function automatic arena_request_t make_request(aaba_pkg::op_t kind, logic [1:0] id,
                                                  logic [31:0] count,
                                                  logic [31:0] align,
                                                  logic [31:0] base);
    arena_request_t req;
    req.op = kind;
    req.id = id;
    req.count = count;
    req.align = align;
    req.base = base;
    return req;
  endfunction

  // Sends one request and books its predicted result once it is accepted.
  // The caller is always just past a rising edge, so each falling edge gets
  // exactly one assignment to in_valid.
  task automatic issue_request(arena_request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    op          <= req.op;
    arena_id    <= req.id;
    byte_count  <= req.count;
    alignment   <= req.align;
    region_base <= req.base;
    do @(posedge clk); while (!in_ready);
    owed_results.push_back(arena_table_apply(req));
  endtask

  // Usually aims at a live arena so that most requests get past the id check.
  function automatic logic [1:0] pick_arena();
    logic [1:0] live_ids[$];
    if ($urandom_range(9) == 0) return 2'($urandom_range(3));
    for (int i = 0; i < aaba_pkg::ARENA_SLOTS; i++) begin
      if (slot_live[i]) live_ids.push_back(i[1:0]);
    end
    if (live_ids.size() == 0) return 2'($urandom_range(3));
    return live_ids[$urandom_range(live_ids.size() - 1)];
  endfunction

  // Builds a random request. Most of them are well-formed creates and
  // allocations against live arenas with small power-of-two alignments;
  // the rest are resets, destroys, odd alignments, huge counts or plain noise.
  function automatic arena_request_t random_request();
    arena_request_t req;
    int unsigned    roll;
    int unsigned    pick;
    req.op = aaba_pkg::op_t'($urandom_range(3));
    req.id = 2'($urandom_range(3));
    req.count = $urandom;
    req.align = $urandom;
    req.base = $urandom;
    roll = $urandom_range(99);
    if (roll < 14) begin
      req.op = aaba_pkg::OP_CREATE;
      pick = $urandom_range(9);
      if (pick == 0) req.count = '0;
      else if (pick > 2) req.count = $urandom_range(1, 4096);
    end else if (roll < 70) begin
      req.op = aaba_pkg::OP_ALLOC;
      req.id = pick_arena();
      pick = $urandom_range(19);
      if (pick < 15) req.align = 32'd1 << $urandom_range(0, 6);
      else if (pick < 18) req.align = 32'd1 << $urandom_range(0, 31);
      else if (pick == 18) req.align = '0;
      pick = $urandom_range(19);
      if (pick < 12) req.count = $urandom_range(0, 64);
      else if (pick < 18) req.count = $urandom_range(0, 1024);
    end else if (roll < 80) begin
      req.op = aaba_pkg::OP_RESET;
      req.id = pick_arena();
    end else if (roll < 90) begin
      req.op = aaba_pkg::OP_DESTROY;
      req.id = pick_arena();
    end
    return req;
  endfunction

  task automatic run_random_mix(int unsigned n);
    for (int unsigned i = 0; i < n; i++) issue_request(random_request());
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // The receiver stalls at random, or solidly while a hold-off is running.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void log_failure(string what, aaba_pkg::result_t want,
                                      aaba_pkg::result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] %s: expected status=%0d granted=%0d address=%h remaining=%h",
               $realtime, what, want.status, want.granted, want.address, want.remaining);
      $display("[%0t] %s:   actual status=%0d granted=%0d address=%h remaining=%h",
               $realtime, what, got.status, got.granted, got.address, got.remaining);
    end
  endfunction

  // Each accepted result is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    aaba_pkg::result_t got;
    aaba_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      got.status = aaba_pkg::status_t'(status);
      got.granted = granted_id;
      got.address = address;
      got.remaining = remaining;
      if (owed_results.size() == 0) begin
        log_failure("result with no request outstanding", '0, got);
      end else begin
        want = owed_results.pop_front();
        if (got.status !== want.status || got.granted !== want.granted ||
            got.address !== want.address || got.remaining !== want.remaining) begin
          log_failure("result mismatch", want, got);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Commands aimed at arenas that do not exist yet, and a zero-size create.
  task automatic test_dead_arena_errors();
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd0, 32'd4, 32'd1, 32'd0));
    issue_request(make_request(aaba_pkg::OP_RESET, 2'd3, 32'd0, 32'd0, 32'd0));
    issue_request(make_request(aaba_pkg::OP_DESTROY, 2'd1, 32'd0, 32'd0, 32'd0));
    issue_request(make_request(aaba_pkg::OP_CREATE, 2'd0, 32'd0, 32'd0, 32'h1234_0000));
  endtask

  // Fills every slot, including the smallest and largest sizes, and then
  // asks for one more arena than the table holds.
  task automatic test_fill_table();
    issue_request(make_request(aaba_pkg::OP_CREATE, 2'd3, 32'd1, 32'd0, 32'h0000_0000));
    issue_request(make_request(aaba_pkg::OP_CREATE, 2'd0, 32'hFFFF_FFFF, 32'd0,
                               32'hFFFF_FFF0));
    issue_request(make_request(aaba_pkg::OP_CREATE, 2'd1, 32'd100, 32'd0, 32'h0000_1000));
    issue_request(make_request(aaba_pkg::OP_CREATE, 2'd2, 32'd64, 32'd0, 32'h8000_0000));
    issue_request(make_request(aaba_pkg::OP_CREATE, 2'd0, 32'd10, 32'd0, 32'hFFFF_FFFF));
  endtask

  // Zero and non-power-of-two alignments, zero-byte allocations, exact fits
  // and requests that are one byte too long.
  task automatic test_alloc_alignment();
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd0, 32'd1, 32'd0, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd0, 32'd1, 32'd3, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd0, 32'd1, 32'd1, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd0, 32'd0, 32'd1, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd0, 32'd1, 32'd1, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd2, 32'd5, 32'd1, 32'd0));
    // A zero-byte allocation still moves the used count up to the alignment.
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd2, 32'd0, 32'd64, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd2, 32'd37, 32'd4, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd2, 32'd36, 32'd4, 32'd0));
  endtask

  // Addresses that wrap past 32 bits and an align-up that would overflow
  // 32 bits if it were not carried out wider.
  task automatic test_alloc_wrap_and_overflow();
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd1, 32'd16, 32'd1, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd1, 32'd8, 32'd32, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd1, 32'd0, 32'h8000_0000, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd1, 32'd1, 32'h8000_0000, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd1, 32'd0, 32'h8000_0000, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd3, 32'hFFFF_FFFF, 32'd1, 32'd0));
  endtask

  // Reset empties an arena, destroy frees the slot for the next create.
  task automatic test_reset_and_destroy();
    issue_request(make_request(aaba_pkg::OP_RESET, 2'd1, 32'd0, 32'd0, 32'd0));
    issue_request(make_request(aaba_pkg::OP_ALLOC, 2'd1, 32'hFFFF_FFFF, 32'd1, 32'd0));
    issue_request(make_request(aaba_pkg::OP_DESTROY, 2'd2, 32'd0, 32'd0, 32'd0));
    issue_request(make_request(aaba_pkg::OP_CREATE, 2'd3, 32'd7, 32'd0, 32'd5));
  endtask

  task automatic test_steady_stream();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_mix(200);
  endtask

  task automatic test_sparse_sender();
    send_idle_pct = 67;
    recv_stall_pct = 0;
    run_random_mix(140);
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 0;
    recv_stall_pct = 67;
    run_random_mix(140);
  endtask

  task automatic test_both_sides_idle();
    send_idle_pct = 23;
    recv_stall_pct = 23;
    run_random_mix(140);
  endtask

  // The receiver goes quiet for a long stretch while requests keep coming,
  // so the block has to fill up and drop in_ready.
  task automatic test_result_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    run_random_mix(60);
  endtask

  initial begin
    for (int i = 0; i < aaba_pkg::ARENA_SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_base[i] = '0;
      slot_size[i] = '0;
      slot_used[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_dead_arena_errors();
    test_fill_table();
    test_alloc_alignment();
    test_alloc_wrap_and_overflow();
    test_reset_and_destroy();
    test_steady_stream();
    test_sparse_sender();
    test_slow_receiver();
    test_both_sides_idle();
    test_result_backpressure();

    @(negedge clk);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (owed_results.size() != 0) @(posedge clk);
    // Give the pipeline time to show any result that nobody asked for.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
